/* sv/hill_cipher_encrypt_assert.svh */
// assertion macros for the hill cipher encryptor checker
`ifndef HILL_CIPHER_ENCRYPT_ASSERT_SVH
`define HILL_CIPHER_ENCRYPT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define HCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define HCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hce_pkg.sv */
// shared types and constants for the hill cipher encryptor
`default_nettype none

package hce_pkg;

  localparam int unsigned ALPHA     = 26;
  localparam int unsigned LOWER_A   = 97;
  localparam int unsigned LOWER_Z   = 122;
  localparam int unsigned UPPER_A   = 65;
  localparam int unsigned UPPER_Z   = 90;
  localparam int unsigned PAD_CODE  = 23;
  localparam int unsigned KEY_W     = 5;
  localparam int unsigned LET_W     = 5;
  localparam int unsigned PROD_W    = 10;
  localparam int unsigned RECIP     = 40329;
  localparam int unsigned RECIP_W   = 16;
  localparam int unsigned RECIP_SH  = 20;
  localparam int unsigned REM_W     = 6;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned KS_W      = 4;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic take;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic emit_req;
    logic last_issue;
    logic pipe_empty;
  } sts_t;

endpackage

`default_nettype wire

/* sv/hce_ctrl.sv */
// controller state machine for the hill cipher encryptor
`default_nettype none

module hce_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output hce_pkg::cmd_t      cmd,
  input  wire hce_pkg::sts_t sts
);

  hce_pkg::state_t state_r;
  hce_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hce_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hce_pkg::ST_IDLE: begin
        if (in_valid && sts.emit_req) begin
          state_nxt = hce_pkg::ST_EMIT;
        end
      end
      hce_pkg::ST_EMIT: begin
        if (sts.last_issue) begin
          state_nxt = hce_pkg::ST_DRAIN;
        end
      end
      hce_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = hce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.take  = 1'b0;
    cmd.issue = 1'b0;
    unique case (state_r)
      hce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      hce_pkg::ST_EMIT: begin
        cmd.issue = 1'b1;
      end
      hce_pkg::ST_DRAIN: begin
        cmd.issue = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/hce_dp.sv */
// datapath: key memory, block buffer, row dot product and mod 26 pipeline
`default_nettype none

module hce_dp #(
  parameter int MAX_KEY_SIZE = 9
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [hce_pkg::KS_W-1:0]     cfg_wr_data,
  input  wire hce_pkg::cmd_t                cmd,
  output hce_pkg::sts_t                     sts,
  input  wire logic                         action,
  input  wire logic [3:0]                   key_row,
  input  wire logic [3:0]                   key_col,
  input  wire logic [hce_pkg::KEY_W-1:0]    key_value,
  input  wire logic [7:0]                   text_byte,
  input  wire logic                         end_of_text,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [hce_pkg::CHAR_W-1:0]        cipher_char,
  output logic                              block_last,
  output logic                              message_last
);

  localparam int CW = $clog2(MAX_KEY_SIZE + 1);
  localparam int IW = $clog2(MAX_KEY_SIZE);
  localparam int SW = $clog2(MAX_KEY_SIZE * 961 + 1);
  localparam int QW = SW - 4;
  localparam int MW = SW + hce_pkg::RECIP_W;
  localparam int KW = hce_pkg::KEY_W;
  localparam int LW = hce_pkg::LET_W;
  localparam int PW = hce_pkg::PROD_W;
  localparam int RW = hce_pkg::REM_W;
  localparam int XW = hce_pkg::CHAR_W;

  // configuration and block state
  logic [hce_pkg::KS_W-1:0]          key_size_r;
  logic [CW-1:0]                     fill_r;
  logic [CW-1:0]                     fill_nxt;
  logic [LW-1:0]                     letters_r [MAX_KEY_SIZE];
  logic [CW-1:0]                     pad_from_r;
  logic                              end_r;
  logic [IW-1:0]                     row_r;
  logic [CW-1:0]                     n_w;
  logic                              is_upper;
  logic                              is_lower;
  logic                              is_letter;
  logic [LW-1:0]                     fold_w;
  logic [CW-1:0]                     fill_after;
  logic                              key_in_range;
  logic                              adv;
  logic                              row_last;

  // key storage
  logic [KW-1:0]                     key_mem [MAX_KEY_SIZE][MAX_KEY_SIZE];
  logic [MAX_KEY_SIZE-1:0]           key_vld_r [MAX_KEY_SIZE];

  // pipeline
  logic                              s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                              s1_bl_r, s2_bl_r, s3_bl_r, s4_bl_r;
  logic                              s1_ml_r, s2_ml_r, s3_ml_r, s4_ml_r;
  logic [KW-1:0]                     krow_r [MAX_KEY_SIZE];
  logic [MAX_KEY_SIZE-1:0]           kvld_r;
  logic [PW-1:0]                     prod_r [MAX_KEY_SIZE];
  logic [PW-1:0]                     prod_nxt [MAX_KEY_SIZE];
  logic [SW-1:0]                     sum_r;
  logic [SW-1:0]                     sum_nxt;
  logic [SW-1:0]                     sum4_r;
  logic [QW-1:0]                     q_r;
  logic [MW-1:0]                     mul_w;
  logic [SW-1:0]                     diff_w;
  logic [RW-1:0]                     rem_w;
  logic                              out_valid_r;
  logic [XW-1:0]                     char_r;
  logic                              bl_r;
  logic                              ml_r;

  always_comb begin
    if (key_size_r == '0) begin
      n_w = CW'(1);
    end else if (int'(key_size_r) > MAX_KEY_SIZE) begin
      n_w = CW'(MAX_KEY_SIZE);
    end else begin
      n_w = CW'(key_size_r);
    end
  end

  assign is_upper  = (text_byte >= 8'(hce_pkg::UPPER_A)) && (text_byte <= 8'(hce_pkg::UPPER_Z));
  assign is_lower  = (text_byte >= 8'(hce_pkg::LOWER_A)) && (text_byte <= 8'(hce_pkg::LOWER_Z));
  assign is_letter = is_upper || is_lower;
  assign fold_w    = is_upper ? LW'(text_byte - 8'(hce_pkg::UPPER_A))
                              : LW'(text_byte - 8'(hce_pkg::LOWER_A));
  assign fill_after = fill_r + CW'(is_letter);
  assign key_in_range = (int'(key_row) < MAX_KEY_SIZE) && (int'(key_col) < MAX_KEY_SIZE);

  assign sts.emit_req = (action == hce_pkg::ACT_TEXT) &&
                        ((fill_after >= n_w) || (end_of_text && (fill_after != '0)));

  assign adv      = !out_valid_r || out_ready;
  assign row_last = (CW'(row_r) == n_w - CW'(1));
  assign sts.last_issue = cmd.issue && adv && row_last;
  assign sts.pipe_empty = !(s1_v_r || s2_v_r || s3_v_r || s4_v_r);

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_wr_en) begin
      fill_nxt = '0;
    end else if (cmd.take && (action == hce_pkg::ACT_TEXT)) begin
      fill_nxt = sts.emit_req ? '0 : fill_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= hce_pkg::KS_W'(3);
      fill_r     <= '0;
      row_r      <= '0;
      end_r      <= 1'b0;
      pad_from_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        key_size_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
      if (cmd.take && sts.emit_req) begin
        row_r      <= '0;
        end_r      <= end_of_text;
        pad_from_r <= fill_after;
      end else if (cmd.issue && adv) begin
        row_r <= row_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (action == hce_pkg::ACT_TEXT) && is_letter) begin
      letters_r[fill_r[IW-1:0]] <= fold_w;
    end
  end

  // key memory, row-wide read
  always_ff @(posedge clk) begin
    if (cmd.take && (action == hce_pkg::ACT_KEY) && key_in_range) begin
      key_mem[key_row[IW-1:0]][key_col[IW-1:0]] <= key_value;
    end
    if (cmd.issue && adv) begin
      krow_r <= key_mem[row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_KEY_SIZE; r++) begin
        key_vld_r[r] <= '0;
      end
    end else if (cmd.take && (action == hce_pkg::ACT_KEY) && key_in_range) begin
      key_vld_r[key_row[IW-1:0]][key_col[IW-1:0]] <= 1'b1;
    end
  end

  // one product per lane
  always_comb begin
    for (int c = 0; c < MAX_KEY_SIZE; c++) begin
      if ((c < int'(n_w)) && kvld_r[c]) begin
        if (c < int'(pad_from_r)) begin
          prod_nxt[c] = PW'(krow_r[c]) * PW'(letters_r[c]);
        end else begin
          prod_nxt[c] = PW'(krow_r[c]) * PW'(hce_pkg::PAD_CODE);
        end
      end else begin
        prod_nxt[c] = '0;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < MAX_KEY_SIZE; c++) begin
      sum_nxt = sum_nxt + SW'(prod_r[c]);
    end
  end

  // reciprocal estimate of the quotient by 26, low by at most one
  assign mul_w  = MW'(sum_r) * MW'(hce_pkg::RECIP);
  assign diff_w = sum4_r - SW'(SW'(q_r) * SW'(hce_pkg::ALPHA));
  always_comb begin
    rem_w = diff_w[RW-1:0];
    if (rem_w >= RW'(hce_pkg::ALPHA)) begin
      rem_w = rem_w - RW'(hce_pkg::ALPHA);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= cmd.issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kvld_r  <= key_vld_r[row_r];
      s1_bl_r <= row_last;
      s1_ml_r <= row_last && end_r;
      prod_r  <= prod_nxt;
      s2_bl_r <= s1_bl_r;
      s2_ml_r <= s1_ml_r;
      sum_r   <= sum_nxt;
      s3_bl_r <= s2_bl_r;
      s3_ml_r <= s2_ml_r;
      q_r     <= mul_w[hce_pkg::RECIP_SH +: QW];
      sum4_r  <= sum_r;
      s4_bl_r <= s3_bl_r;
      s4_ml_r <= s3_ml_r;
      char_r  <= XW'(hce_pkg::LOWER_A) + XW'(rem_w);
      bl_r    <= s4_bl_r;
      ml_r    <= s4_ml_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign cipher_char  = char_r;
  assign block_last   = bl_r;
  assign message_last = ml_r;

endmodule

`default_nettype wire

/* sv/hill_cipher_encrypt.sv */
// path: each block row passes the key row, product, sum, quotient and output registers
// throughput: one byte per cycle while no block is due; a block of n letters holds
//   the input until its key rows, one per cycle unless out_tready stalls, clear the lane pipeline
// reset: synchronous active low; clears key matrix (valid bits), fill count, key size to 3
// stalls on out_tready freeze the whole row pipeline
`default_nettype none

module hill_cipher_encrypt #(
  parameter int MAX_KEY_SIZE = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,   // key_size
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,      // key_row, key_col, key_value, text_byte, zero pad
  input  wire logic        in_tuser,      // action
  input  wire logic        in_tlast,      // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,     // cipher_char, zero pad
  output logic             out_tuser,     // block_last
  output logic             out_tlast      // message_last
);

  hce_pkg::cmd_t                 cmd;
  hce_pkg::sts_t                 sts;
  logic [hce_pkg::CHAR_W-1:0]    cipher_char;

  hce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hce_dp #(
    .MAX_KEY_SIZE (MAX_KEY_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .action       (in_tuser),
    .key_row      (in_tdata[3:0]),
    .key_col      (in_tdata[7:4]),
    .key_value    (in_tdata[12:8]),
    .text_byte    (in_tdata[20:13]),
    .end_of_text  (in_tlast),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .cipher_char  (cipher_char),
    .block_last   (out_tuser),
    .message_last (out_tlast)
  );

  assign out_tdata = {1'b0, cipher_char};

endmodule

`default_nettype wire

/* sv/hce_chk.sv */
// port-level checker for the hill cipher encryptor, bound to the top level
`default_nettype none
`include "hill_cipher_encrypt_assert.svh"

module hce_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  logic       in_acc;
  logic       out_stall;
  logic [9:0] out_q;
  logic       out_ok;
  logic       mid_blk;
  logic       acc_idle;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_q     = {out_tlast, out_tuser, out_tdata};
  assign out_ok    = (!out_tlast || out_tuser) && (out_tdata >= 8'd97) && (out_tdata <= 8'd122);
  assign mid_blk   = out_tvalid && !out_tuser;
  assign acc_idle  = in_acc && !out_tvalid;

  // held item stays put
  `HCE_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_q), "item changed")

  // message end only on a block end, always a lowercase letter
  `HCE_ASSERT_IMP(a_out_form, clk, rst_n, out_tvalid, out_ok, "bad output item")

  // mid-block character means the block is still in flight
  `HCE_ASSERT_IMP(a_busy_mid_block, clk, rst_n, mid_blk, !in_tready, "input open mid block")

  // no result can appear in the cycle after an item is accepted while the output is empty
  `HCE_ASSERT_NXT(a_min_latency, clk, rst_n, acc_idle, !out_tvalid, "result too early")

endmodule

bind hill_cipher_encrypt hce_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* tb/tb_hill_cipher_encrypt.sv */
// self-checking testbench for the hill cipher encryptor: key loads, text streams, key sizes
`default_nettype none

module tb_hill_cipher_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMAX = 9;

  typedef struct packed {
    logic [hce_pkg::CHAR_W-1:0] ch;
    logic                       blk_end;
    logic                       msg_end;
  } cipher_char_t;

  class hill_scoreboard;
    logic [hce_pkg::KEY_W-1:0] key_tab [KMAX][KMAX];
    logic [hce_pkg::LET_W-1:0] letters [KMAX];
    int unsigned               fill;
    logic [hce_pkg::KS_W-1:0]  ksize;
    cipher_char_t              cipher_due_q [$];
    int unsigned               errors;

    function new();
      foreach (key_tab[r, c]) key_tab[r][c] = '0;
      fill = 0;
      ksize = 4'd3;
      errors = 0;
    endfunction

    function void set_key_size(logic [hce_pkg::KS_W-1:0] v);
      ksize = v;
      fill = 0;
    endfunction

    function int unsigned block_n();
      int unsigned n;
      n = ksize;
      if (n < 1) n = 1;
      if (n > KMAX) n = KMAX;
      return n;
    endfunction

    function void encrypt_block(int unsigned n, logic eot);
      int unsigned acc;
      cipher_char_t c_exp;
      for (int r = 0; r < n; r++) begin
        acc = 0;
        for (int c = 0; c < n; c++) acc += key_tab[r][c] * letters[c];
        c_exp.ch = hce_pkg::CHAR_W'(hce_pkg::LOWER_A + acc % hce_pkg::ALPHA);
        c_exp.blk_end = (r == n - 1);
        c_exp.msg_end = eot && (r == n - 1);
        cipher_due_q.push_back(c_exp);
      end
      fill = 0;
    endfunction

    function void take_item(logic act, logic [3:0] row, logic [3:0] col,
                            logic [hce_pkg::KEY_W-1:0] kval, logic [7:0] text_b,
                            logic eot);
      int unsigned n;
      n = block_n();
      if (act == hce_pkg::ACT_KEY) begin
        if (row < KMAX && col < KMAX) key_tab[row][col] = kval;
        return;
      end
      if (fill >= n) fill = 0;
      if (text_b >= hce_pkg::UPPER_A && text_b <= hce_pkg::UPPER_Z) begin
        letters[fill] = hce_pkg::LET_W'(text_b - hce_pkg::UPPER_A);
        fill++;
      end else if (text_b >= hce_pkg::LOWER_A && text_b <= hce_pkg::LOWER_Z) begin
        letters[fill] = hce_pkg::LET_W'(text_b - hce_pkg::LOWER_A);
        fill++;
      end
      if (fill >= n) begin
        encrypt_block(n, eot);
      end else if (eot && fill > 0) begin
        for (int i = fill; i < n; i++) letters[i] = hce_pkg::LET_W'(hce_pkg::PAD_CODE);
        encrypt_block(n, 1'b1);
      end
    endfunction

    function void check_char(logic [7:0] data, logic bl, logic ml);
      cipher_char_t c_exp;
      if (cipher_due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: actual data %h block_last %b message_last %b",
                 $time, data, bl, ml);
        return;
      end
      c_exp = cipher_due_q.pop_front();
      if (data !== {1'b0, c_exp.ch} || bl !== c_exp.blk_end || ml !== c_exp.msg_end) begin
        errors++;
        $display("%0t: mismatch: expected data %h block_last %b message_last %b, actual %h %b %b",
                 $time, {1'b0, c_exp.ch}, c_exp.blk_end, c_exp.msg_end, data, bl, ml);
      end
    endfunction

    function int unsigned pending();
      return cipher_due_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // key_row, key_col, key_value, text_byte, zero pad
  logic        in_tuser;    // action
  logic        in_tlast;    // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // cipher_char, zero pad
  logic        out_tuser;   // block_last
  logic        out_tlast;   // message_last

  hill_scoreboard sb;
  bit quiet;
  bit long_hold;

  hill_cipher_encrypt #(.MAX_KEY_SIZE(KMAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_char(out_tdata, out_tuser, out_tlast);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic act, logic [3:0] row, logic [3:0] col,
                           logic [hce_pkg::KEY_W-1:0] kval, logic [7:0] text_b, logic eot);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tlast  <= eot;
    in_tdata  <= {3'b000, text_b, kval, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(act, row, col, kval, text_b, eot);
  endtask

  task automatic send_key(logic [3:0] row, logic [3:0] col, logic [hce_pkg::KEY_W-1:0] kval);
    send_item(hce_pkg::ACT_KEY, row, col, kval, 8'($urandom_range(0, 255)), 1'($urandom));
  endtask

  task automatic send_text(logic [7:0] text_b, logic eot);
    send_item(hce_pkg::ACT_TEXT, 4'($urandom), 4'($urandom), 5'($urandom), text_b, eot);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_key_size(logic [3:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_key_size(v);
  endtask

  function automatic logic [7:0] rand_text_byte();
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'(hce_pkg::UPPER_A + $urandom_range(0, 25));
      4, 5, 6:    return 8'(hce_pkg::LOWER_A + $urandom_range(0, 25));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [3:0] dir_sizes [5];
    logic [3:0] ksz;
    int unsigned n;
    int unsigned key_cnt;
    int unsigned text_cnt;

    dir_sizes = '{4'd1, 4'd9, 4'd0, 4'd15, 4'd2};
    sb = new();
    quiet = 0;
    long_hold = 0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= hce_pkg::ACT_KEY;
    in_tlast    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: key extremes, ignored positions, end flag on key write
    send_item(hce_pkg::ACT_KEY, 4'd0, 4'd0, 5'd25, 8'hFF, 1'b0);
    send_item(hce_pkg::ACT_KEY, 4'd1, 4'd1, 5'd31, 8'h00, 1'b0);
    send_item(hce_pkg::ACT_KEY, 4'd2, 4'd2, 5'd1, 8'hAA, 1'b1);
    send_item(hce_pkg::ACT_KEY, 4'd0, 4'd2, 5'd7, 8'h55, 1'b0);
    send_item(hce_pkg::ACT_KEY, 4'd8, 4'd8, 5'd31, 8'h00, 1'b0);
    send_item(hce_pkg::ACT_KEY, 4'd9, 4'd0, 5'd5, 8'h00, 1'b0);
    send_item(hce_pkg::ACT_KEY, 4'd0, 4'd15, 5'd5, 8'h00, 1'b0);
    send_item(hce_pkg::ACT_KEY, 4'd15, 4'd15, 5'd31, 8'hFF, 1'b1);
    send_item(hce_pkg::ACT_KEY, 4'd2, 4'd0, 5'd0, 8'h00, 1'b0);
    // directed: letter edges, non-letters, padding, flags
    send_text(8'd65, 1'b0);
    send_text(8'd64, 1'b0);
    send_text(8'd91, 1'b0);
    send_text(8'd90, 1'b0);
    send_text(8'd96, 1'b0);
    send_text(8'd123, 1'b0);
    send_text(8'd0, 1'b0);
    send_text(8'd255, 1'b0);
    send_text(8'd97, 1'b0);
    send_text(8'd122, 1'b1);
    send_text(8'd35, 1'b1);
    send_text(8'd98, 1'b0);
    send_text(8'd67, 1'b0);
    send_text(8'd100, 1'b1);
    send_text(8'd120, 1'b0);

    for (int p = 0; p < 10; p++) begin
      ksz = (p < 5) ? dir_sizes[p] : 4'($urandom_range(0, 15));
      wait_idle();
      if (p == 9) quiet = 1;
      write_key_size(ksz);
      n = sb.block_n();
      key_cnt = (n * n <= 16) ? n * n : $urandom_range(10, 20);
      for (int k = 0; k < key_cnt; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_key(4'($urandom), 4'($urandom), 5'($urandom));
        else if (n * n <= 16)
          send_key(4'(k / n), 4'(k % n), 5'($urandom_range(0, 25)));
        else
          send_key(4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
                   5'($urandom_range(0, 25)));
      end
      if (p == 1) long_hold = 1;
      text_cnt = $urandom_range(15, 25);
      for (int t = 0; t < text_cnt; t++)
        send_text(rand_text_byte(), $urandom_range(0, 9) == 0);
    end

    wait_idle();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
